// ===== src/ocp_pkg.sv =====
`default_nettype none
package ocp_pkg;

    // prediction table geometry
    localparam int TABLE_DEPTH = 256 * 256;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    // front to back queue
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // configuration register indexes
    localparam logic [0:0] CFG_DIRECTION     = 1'b0;
    localparam logic [0:0] CFG_DECODE_LENGTH = 1'b1;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       flush;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_beat;

    // work classes handed from front to back
    typedef enum logic [1:0] {
        K_ENC   = 2'd0,
        K_FLUSH = 2'd1,
        K_DEC   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_cmd;

    // configuration side effects seen by the back end
    typedef struct packed {
        logic        wr_dir;
        logic        wr_len;
        logic [31:0] dec_len;
    } t_ctl;

endpackage
`default_nettype wire

// ===== src/ocp_queue.sv =====
`default_nettype none
module ocp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ocp_pkg::t_cmd i_wdata,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output ocp_pkg::t_cmd      o_rdata
);

    ocp_pkg::t_cmd               r_ent [ocp_pkg::QDEPTH];
    logic [ocp_pkg::QAW-1:0]     r_wp, n_wp;
    logic [ocp_pkg::QAW-1:0]     r_rp, n_rp;
    logic [ocp_pkg::QCW-1:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == ocp_pkg::QCW'(ocp_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_ent[r_rp];

    // pointer and count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == ocp_pkg::QAW'(ocp_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == ocp_pkg::QAW'(ocp_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

// ===== src/ocp_front.sv =====
`default_nettype none
module ocp_front (
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire ocp_pkg::t_in_beat i_in_data,
    input  wire logic              i_dir,
    input  wire logic              i_clearing,
    input  wire logic              i_full,
    output logic                   o_push,
    output ocp_pkg::t_cmd          o_cmd
);

    logic accept;

    // hold off upstream while the queue is full or the table is being cleared
    assign o_in_stall = i_full | i_clearing;
    assign accept     = i_in_valid & ~o_in_stall;

    // classify the beat; a flush while decoding has no effect and is dropped
    always_comb begin
        o_cmd.data = i_in_data.data_byte;
        o_push     = accept;
        if (i_dir == ocp_pkg::DIR_DECODE) begin
            o_cmd.kind = ocp_pkg::K_DEC;
            if (i_in_data.flush) begin
                o_push = 1'b0;
            end
        end else if (i_in_data.flush) begin
            o_cmd.kind = ocp_pkg::K_FLUSH;
        end else begin
            o_cmd.kind = ocp_pkg::K_ENC;
        end
    end

endmodule
`default_nettype wire

// ===== src/ocp_back.sv =====
`default_nettype none
module ocp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire ocp_pkg::t_cmd      i_cmd,
    output logic                    o_pop,
    input  wire ocp_pkg::t_ctl      i_ctl,
    output logic                    o_clearing,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ocp_pkg::t_out_beat      o_out_data
);

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_ENC_RD   = 7'b0000100,
        S_ENC_EMIT = 7'b0001000,
        S_DEC_BIT  = 7'b0010000,
        S_DEC_RD   = 7'b0100000,
        S_FIN      = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // prediction table
    logic [7:0]                   r_tab [ocp_pkg::TABLE_DEPTH];
    logic [7:0]                   r_rd;
    logic                         mem_we;
    logic [ocp_pkg::TABLE_AW-1:0] mem_wa;
    logic [7:0]                   mem_wd;
    logic [ocp_pkg::TABLE_AW-1:0] ctx;
    logic [ocp_pkg::TABLE_AW-1:0] r_clr, n_clr;

    // context and bit packer
    logic [7:0]  r_prev, n_prev;
    logic [7:0]  r_pprev, n_pprev;
    logic [2:0]  r_pcnt, n_pcnt;
    logic [7:0]  r_part, n_part;
    logic        r_lit, n_lit;
    logic [2:0]  r_lbs, n_lbs;
    logic [31:0] r_dcnt, n_dcnt;

    // per item working registers
    logic [7:0]  r_data, n_data;
    logic [15:0] r_acc, n_acc;
    logic [4:0]  r_acnt, n_acnt;
    logic [7:0]  r_sh, n_sh;
    logic [2:0]  r_bi, n_bi;

    // held result (last still unknown) and output register
    logic        r_pvld, n_pvld;
    logic [7:0]  r_pbyte, n_pbyte;
    logic        r_ovld, n_ovld;
    logic [7:0]  r_obyte, n_obyte;
    logic        r_olast, n_olast;

    logic       out_free;
    logic       go;
    logic       cur_bit;
    logic       hit;
    logic [8:0] enc_bits;
    logic [7:0] lit_byte;
    logic       emit_req;
    logic [7:0] emit_byte;

    assign ctx        = {r_prev, r_pprev};
    assign out_free   = ~r_ovld | ~i_out_stall;
    assign go         = ~r_pvld | out_free;
    assign cur_bit    = r_sh[r_bi];
    assign hit        = (r_rd == r_data);
    assign enc_bits   = hit ? 9'd1 : {r_data, 1'b0};
    assign lit_byte   = r_part | ({7'b0, cur_bit} << r_lbs);
    assign o_clearing = (r_state == S_CLEAR);
    assign o_pop      = (r_state == S_IDLE) & i_cmd_valid;

    assign o_out_valid         = r_ovld;
    assign o_out_data.out_byte = r_obyte;
    assign o_out_data.last     = r_olast;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_prev   = r_prev;
        n_pprev  = r_pprev;
        n_pcnt   = r_pcnt;
        n_part   = r_part;
        n_lit    = r_lit;
        n_lbs    = r_lbs;
        n_dcnt   = r_dcnt;
        n_data   = r_data;
        n_acc    = r_acc;
        n_acnt   = r_acnt;
        n_sh     = r_sh;
        n_bi     = r_bi;
        n_pvld   = r_pvld;
        n_pbyte  = r_pbyte;
        n_ovld   = r_ovld & i_out_stall;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        mem_we   = 1'b0;
        mem_wa   = ctx;
        mem_wd   = r_data;
        emit_req  = 1'b0;
        emit_byte = r_acc[7:0];

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                n_clr  = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        ocp_pkg::K_ENC: begin
                            n_data  = i_cmd.data;
                            n_state = S_ENC_RD;
                        end
                        ocp_pkg::K_FLUSH: begin
                            if (r_pcnt != '0) begin
                                n_pvld  = 1'b1;
                                n_pbyte = r_part;
                                n_part  = '0;
                                n_pcnt  = '0;
                            end
                            n_state = S_FIN;
                        end
                        ocp_pkg::K_DEC: begin
                            n_sh    = i_cmd.data;
                            n_bi    = '0;
                            n_state = S_DEC_BIT;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_ENC_RD: begin
                // append flag (and literal on a miss) above the pending bits
                n_acc  = {8'b0, r_part} | ({7'b0, enc_bits} << r_pcnt);
                n_acnt = {2'b0, r_pcnt} + (hit ? 5'd1 : 5'd9);
                if (!hit) begin
                    mem_we = 1'b1;
                end
                n_prev  = r_data;
                n_pprev = r_prev;
                n_state = S_ENC_EMIT;
            end
            S_ENC_EMIT: begin
                if (r_acnt >= 5'd8) begin
                    if (go) begin
                        emit_req  = 1'b1;
                        emit_byte = r_acc[7:0];
                        n_acc     = r_acc >> 8;
                        n_acnt    = r_acnt - 5'd8;
                    end
                end else begin
                    n_part  = r_acc[7:0];
                    n_pcnt  = r_acnt[2:0];
                    n_state = S_FIN;
                end
            end
            S_DEC_BIT: begin
                if (r_dcnt >= i_ctl.dec_len) begin
                    n_state = S_FIN;
                end else if (r_lit) begin
                    if (r_lbs == 3'd7) begin
                        if (go) begin
                            mem_we    = 1'b1;
                            mem_wd    = lit_byte;
                            emit_req  = 1'b1;
                            emit_byte = lit_byte;
                            n_prev    = lit_byte;
                            n_pprev   = r_prev;
                            n_dcnt    = r_dcnt + 32'd1;
                            n_lit     = 1'b0;
                            n_lbs     = '0;
                            n_part    = '0;
                            n_bi      = r_bi + 1'b1;
                            if (r_bi == 3'd7) begin
                                n_state = S_FIN;
                            end
                        end
                    end else begin
                        n_part = lit_byte;
                        n_lbs  = r_lbs + 1'b1;
                        n_bi   = r_bi + 1'b1;
                        if (r_bi == 3'd7) begin
                            n_state = S_FIN;
                        end
                    end
                end else if (cur_bit) begin
                    // predicted byte: table read lands next cycle
                    n_state = S_DEC_RD;
                end else begin
                    n_lit  = 1'b1;
                    n_lbs  = '0;
                    n_part = '0;
                    n_bi   = r_bi + 1'b1;
                    if (r_bi == 3'd7) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_DEC_RD: begin
                if (go) begin
                    emit_req  = 1'b1;
                    emit_byte = r_rd;
                    n_prev    = r_rd;
                    n_pprev   = r_prev;
                    n_dcnt    = r_dcnt + 32'd1;
                    n_bi      = r_bi + 1'b1;
                    n_state   = (r_bi == 3'd7) ? S_FIN : S_DEC_BIT;
                end
            end
            S_FIN: begin
                // the held result is the item's last one
                if (r_pvld) begin
                    if (out_free) begin
                        n_ovld  = 1'b1;
                        n_obyte = r_pbyte;
                        n_olast = 1'b1;
                        n_pvld  = 1'b0;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // a new result pushes the held one out as not last
        if (emit_req) begin
            if (r_pvld) begin
                n_ovld  = 1'b1;
                n_obyte = r_pbyte;
                n_olast = 1'b0;
            end
            n_pvld  = 1'b1;
            n_pbyte = emit_byte;
        end

        // configuration side effects
        if (i_ctl.wr_dir) begin
            n_pcnt = '0;
            n_part = '0;
            n_lit  = 1'b0;
            n_lbs  = '0;
        end
        if (i_ctl.wr_len) begin
            n_dcnt = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_prev  <= '0;
            r_pprev <= '0;
            r_pcnt  <= '0;
            r_part  <= '0;
            r_lit   <= 1'b0;
            r_lbs   <= '0;
            r_dcnt  <= '0;
            r_pvld  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_prev  <= n_prev;
            r_pprev <= n_pprev;
            r_pcnt  <= n_pcnt;
            r_part  <= n_part;
            r_lit   <= n_lit;
            r_lbs   <= n_lbs;
            r_dcnt  <= n_dcnt;
            r_pvld  <= n_pvld;
            r_ovld  <= n_ovld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_acc   <= n_acc;
        r_acnt  <= n_acnt;
        r_sh    <= n_sh;
        r_bi    <= n_bi;
        r_pbyte <= n_pbyte;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    // table: one write port, registered read at the current context
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tab[mem_wa] <= mem_wd;
        end
        r_rd <= r_tab[ctx];
    end

    a_idle_no_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pvld)
        else $error("held result left over at idle");

    a_dcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC_BIT || r_state == S_DEC_RD) |-> (r_dcnt <= i_ctl.dec_len))
        else $error("decoded count past decode length");

    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENC_EMIT) |-> (r_acnt <= 5'd16))
        else $error("encode accumulator overflow");

    a_lit_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_lit |-> (r_lbs == '0))
        else $error("literal bit count without literal");

endmodule
`default_nettype wire

// ===== src/order2_context_predictor_codec.sv =====
`default_nettype none
// Encode: a beat goes through queue pop, table read, packing (which emits each finished
// output byte, waiting while the output stalls) and a closing state; a flush is popped and
// closed. Decode: a beat is popped, then each bit is handled in turn up to the decode length,
// each predicted byte also waiting for its dependent table read, and the beat is closed.
// Reset (synchronous, i_rst_n low) clears control state, then the table is swept to
// zero over all 65536 entries, during which input beats stall; config writes are still taken.
module order2_context_predictor_codec (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire ocp_pkg::t_in_beat   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output ocp_pkg::t_out_beat       o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [0:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_wdata
);

    logic          r_dir;
    logic [31:0]   r_dlen;
    ocp_pkg::t_ctl ctl;
    ocp_pkg::t_cmd f_cmd;
    ocp_pkg::t_cmd q_cmd;
    logic          f_push;
    logic          q_full;
    logic          q_valid;
    logic          b_pop;
    logic          b_clearing;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= ocp_pkg::DIR_ENCODE;
            r_dlen <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ocp_pkg::CFG_DIRECTION:     r_dir  <= i_cfg_wdata[0];
                ocp_pkg::CFG_DECODE_LENGTH: r_dlen <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ctl.wr_dir  = i_cfg_we & (i_cfg_idx == ocp_pkg::CFG_DIRECTION);
    assign ctl.wr_len  = i_cfg_we & (i_cfg_idx == ocp_pkg::CFG_DECODE_LENGTH);
    assign ctl.dec_len = r_dlen;

    ocp_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_dir      (r_dir),
        .i_clearing (b_clearing),
        .i_full     (q_full),
        .o_push     (f_push),
        .o_cmd      (f_cmd)
    );

    ocp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (b_pop),
        .o_rdata (q_cmd)
    );

    ocp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (b_pop),
        .i_ctl       (ctl),
        .o_clearing  (b_clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
